// ----- hdl/ebjs_pkg.sv -----
// Shared types, codes and the queue-order comparator for the backfill scheduler.
package ebjs_pkg;

	localparam int WAIT_DEPTH_DEF = 64;
	localparam int RUN_DEPTH_DEF = 64;

	// Commands broadcast to a row of cells.
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_HOLD = 2'd0;
	localparam cmd_t CMD_ROT = 2'd1;
	localparam cmd_t CMD_INS = 2'd2;
	localparam cmd_t CMD_DEL = 2'd3;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_TRY = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNKNOWN = 3'd1;
	localparam logic [2:0] ST_MISSED = 3'd2;
	localparam logic [2:0] ST_NORES = 3'd3;
	localparam logic [2:0] ST_WORSE = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic [2:0] MODE_LARGEST = 3'd1;
	localparam logic [2:0] MODE_SMALLEST = 3'd2;
	localparam logic [2:0] MODE_LONGEST = 3'd3;
	localparam logic [2:0] MODE_SHORTEST = 3'd4;
	localparam logic [2:0] MODE_FIT = 3'd5;

	localparam logic REG_ORDER_MODE = 1'b0;
	localparam logic REG_CORES = 1'b1;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] procs;
		logic [31:0] rt;
		logic [31:0] arr;
		logic [15:0] nodes;
	} wait_ent_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] nodes;
		logic [31:0] fin;
	} run_ent_t;

	// True if job a goes before job b. Later tests take priority, so they are
	// written from the last tie breaker up to the primary key.
	function automatic logic ahead(input logic [2:0] mode, input wait_ent_t a,
			input wait_ent_t b);
		logic r;
		r = (a.arr != b.arr) ? (a.arr < b.arr) : (a.id < b.id);
		if (mode == MODE_SHORTEST && a.rt != b.rt) r = a.rt < b.rt;
		if ((mode == MODE_LONGEST || mode == MODE_FIT) && a.rt != b.rt) r = a.rt > b.rt;
		if (mode == MODE_SMALLEST && a.procs != b.procs) r = a.procs < b.procs;
		if ((mode == MODE_LARGEST || mode == MODE_FIT) && a.procs != b.procs)
			r = a.procs > b.procs;
		return r;
	endfunction

endpackage

// ----- hdl/ebjs_cell.sv -----
// One storage cell of a job table row; shifts, rotates or loads from its neighbors.
module ebjs_cell
	import ebjs_pkg::*;
#(
	parameter int W = 64,
	parameter int AW = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  cmd_t          cmd,
	input  logic [AW-1:0] pos,
	input  logic [W-1:0]  left,
	input  logic [W-1:0]  right,
	input  logic [W-1:0]  newd,
	output logic [W-1:0]  q
);

	localparam logic [AW-1:0] ME = AW'(IDX);

	logic [W-1:0] q_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ROT: q_q <= right;
			CMD_INS: begin
				if (ME > pos) q_q <= left;
				else if (ME == pos) q_q <= newd;
			end
			CMD_DEL: begin
				if (ME >= pos) q_q <= right;
			end
			default: q_q <= q_q;
		endcase
	end

	assign q = q_q;

endmodule

// ----- hdl/ebjs_div.sv -----
// Restoring divider, one quotient bit per cycle, for node counts.
module ebjs_div
	import ebjs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] num,
	input  logic [8:0]  den,
	output logic        done,
	output logic [15:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [8:0]  rem_q;
	logic [16:0] sh_q;
	logic [8:0]  den_q;
	logic [9:0]  trial;
	logic [9:0]  diff;
	logic        ge;

	assign trial = {rem_q, sh_q[16]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q <= '0;
				end
			end else begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				rem_q <= '0;
				sh_q <= num;
				den_q <= den;
			end
		end else begin
			rem_q <= ge ? diff[8:0] : trial[8:0];
			sh_q <= {sh_q[15:0], ge};
		end
	end

	assign done = done_q;
	assign quo = sh_q[15:0];

endmodule

// ----- hdl/easy_backfill_job_scheduler.sv -----
// EASY backfilling scheduler: sequencer over two rows of table cells.
// From acceptance to the result strobe, arrive, finish and try_start each scan the table
// rows, and every scan rotates a row.
// After a cores_per_node write the next item first recomputes waiting node counts, one
// division per waiting job. One transaction at a time while busy is high.
// done is high one cycle, the receiver cannot stall; reset clears counts and the reservation.
module easy_backfill_job_scheduler
	import ebjs_pkg::*;
#(
	parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
	parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] now_time,
	input  logic [15:0] job_id,
	input  logic [15:0] procs_needed,
	input  logic [31:0] est_runtime,
	input  logic [15:0] free_nodes,
	output logic        done,
	output logic        started,
	output logic [15:0] started_job,
	output logic [31:0] reservation,
	output logic [2:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WAW = $clog2(WAIT_DEPTH);
	localparam int WCW = $clog2(WAIT_DEPTH + 1);
	localparam int RAW = $clog2(RUN_DEPTH);
	localparam int RCW = $clog2(RUN_DEPTH + 1);
	localparam int CW = (WCW > RCW) ? WCW : RCW;
	localparam int ACC_W = 16 + RCW;
	localparam int WW = $bits(wait_ent_t);
	localparam int RW = $bits(run_ent_t);
	localparam logic [CW-1:0] WLAST = CW'(WAIT_DEPTH - 1);
	localparam logic [CW-1:0] RLAST = CW'(RUN_DEPTH - 1);
	localparam logic [WCW-1:0] WFULL = WCW'(WAIT_DEPTH);
	localparam logic [RCW-1:0] RFULL = RCW'(RUN_DEPTH);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_NDIV = 5'd2;
	localparam logic [4:0] S_ADIV = 5'd3;
	localparam logic [4:0] S_ASCAN = 5'd4;
	localparam logic [4:0] S_AINS = 5'd5;
	localparam logic [4:0] S_AHEAD = 5'd6;
	localparam logic [4:0] S_FSCAN = 5'd7;
	localparam logic [4:0] S_FDEL = 5'd8;
	localparam logic [4:0] S_TRSCAN = 5'd9;
	localparam logic [4:0] S_TWSCAN = 5'd10;
	localparam logic [4:0] S_TFND = 5'd11;
	localparam logic [4:0] S_TPOS = 5'd12;
	localparam logic [4:0] S_TRINS = 5'd13;
	localparam logic [4:0] S_TWDEL = 5'd14;
	localparam logic [4:0] S_G0 = 5'd15;
	localparam logic [4:0] S_GSCAN = 5'd16;
	localparam logic [4:0] S_GEND = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	logic [4:0]       state_q;
	logic [1:0]       op_q;
	logic [31:0]      now_q;
	logic [15:0]      id_q;
	logic [15:0]      procs_q;
	logic [31:0]      rt_q;
	logic [15:0]      freen_q;
	logic [WCW-1:0]   wcnt_q;
	logic [RCW-1:0]   rcnt_q;
	logic [31:0]      reserved_q;
	logic [16:0]      prev_head_q;
	logic             stale_q;
	logic [2:0]       mode_q;
	logic [8:0]       cores_q;
	logic [CW-1:0]    j_q;
	logic             hit_q;
	logic             dup_q;
	logic             gok_q;
	logic             div_run_q;
	logic [WAW-1:0]   posw_q;
	logic [RAW-1:0]   posr_q;
	logic [15:0]      newn_q;
	logic [2:0]       st_q;
	logic             started_q;
	logic [15:0]      sid_q;
	wait_ent_t        pick_q;
	logic [15:0]      headn_q;
	logic [ACC_W-1:0] acc_q;
	logic [15:0]      gfree_q;
	logic [31:0]      gnew_q;
	logic [31:0]      fin_q;

	cmd_t           wcmd, rcmd;
	logic [WAW-1:0] wpos;
	logic [RAW-1:0] rpos;
	logic [WW-1:0]  wnew, wwrap;
	logic [RW-1:0]  rnew, rwrap;
	logic [WW-1:0]  wq [WAIT_DEPTH];
	logic [WW-1:0]  wleft [WAIT_DEPTH];
	logic [WW-1:0]  wright [WAIT_DEPTH];
	logic [RW-1:0]  rq [RUN_DEPTH];
	logic [RW-1:0]  rleft [RUN_DEPTH];
	logic [RW-1:0]  rright [RUN_DEPTH];
	wait_ent_t      wtap, nv, wtap_n;
	run_ent_t       rtap;

	logic           div_start, div_done;
	logic [16:0]    div_num;
	logic [8:0]     c_eff;
	logic [15:0]    div_quo;

	logic           accept, wr_en;
	logic           j_in_w, j_in_r;
	logic [32:0]    run_sum, pick_sum;
	logic [ACC_W-1:0] acc_n;
	logic [ACC_W-1:0] avail_left;
	logic [32:0]    last_p1;
	logic [2:0]     g_code;

	assign accept = start && (state_q == S_IDLE);
	assign wr_en = psel && penable && pwrite;
	assign busy = state_q != S_IDLE;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CORES) ? {23'd0, cores_q} : {29'd0, mode_q};

	assign wtap = wait_ent_t'(wq[0]);
	assign rtap = run_ent_t'(rq[0]);
	assign nv = '{id: id_q, procs: procs_q, rt: rt_q, arr: now_q, nodes: newn_q};
	assign j_in_w = j_q < CW'(wcnt_q);
	assign j_in_r = j_q < CW'(rcnt_q);
	assign run_sum = {1'b0, now_q} + {1'b0, wtap.rt};
	assign pick_sum = {1'b0, now_q} + {1'b0, pick_q.rt};
	assign acc_n = acc_q + ACC_W'(rtap.nodes);
	assign avail_left = acc_q - ACC_W'(wtap.nodes);
	assign last_p1 = {1'b0, reserved_q} + 33'd1;
	assign c_eff = (cores_q == 9'd0) ? 9'd1 : cores_q;
	assign div_num = (state_q == S_NDIV) ?
		(17'(wtap.procs) + 17'(c_eff) - 17'd1) : (17'(procs_q) + 17'(c_eff) - 17'd1);

	always_comb begin
		wtap_n = wtap;
		wtap_n.nodes = div_quo;
	end

	ebjs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (c_eff),
		.done   (div_done),
		.quo    (div_quo)
	);

	genvar gi;
	generate
		for (gi = 0; gi < WAIT_DEPTH; gi++) begin : g_wait
			if (gi == 0) begin : g_first
				assign wleft[gi] = wnew;
			end else begin : g_mid
				assign wleft[gi] = wq[gi-1];
			end
			if (gi == WAIT_DEPTH - 1) begin : g_last
				assign wright[gi] = wwrap;
			end else begin : g_inner
				assign wright[gi] = wq[gi+1];
			end
			ebjs_cell #(.W(WW), .AW(WAW), .IDX(gi)) u_cell (
				.clk   (clk),
				.cmd   (wcmd),
				.pos   (wpos),
				.left  (wleft[gi]),
				.right (wright[gi]),
				.newd  (wnew),
				.q     (wq[gi])
			);
		end
		for (gi = 0; gi < RUN_DEPTH; gi++) begin : g_run
			if (gi == 0) begin : g_first
				assign rleft[gi] = rnew;
			end else begin : g_mid
				assign rleft[gi] = rq[gi-1];
			end
			if (gi == RUN_DEPTH - 1) begin : g_last
				assign rright[gi] = rwrap;
			end else begin : g_inner
				assign rright[gi] = rq[gi+1];
			end
			ebjs_cell #(.W(RW), .AW(RAW), .IDX(gi)) u_cell (
				.clk   (clk),
				.cmd   (rcmd),
				.pos   (rpos),
				.left  (rleft[gi]),
				.right (rright[gi]),
				.newd  (rnew),
				.q     (rq[gi])
			);
		end
	endgenerate

	// Row commands. A full rotation brings every entry past cell zero and restores order.
	always_comb begin
		wcmd = CMD_HOLD;
		rcmd = CMD_HOLD;
		wpos = posw_q;
		rpos = posr_q;
		wnew = nv;
		wwrap = wq[0];
		rnew = {pick_q.id, pick_q.nodes, fin_q};
		rwrap = rq[0];
		div_start = 1'b0;
		case (state_q)
			S_NDIV: begin
				if (!j_in_w) begin
					wcmd = CMD_ROT;
				end else if (!div_run_q) begin
					div_start = 1'b1;
				end else if (div_done) begin
					wcmd = CMD_ROT;
					wwrap = wtap_n;
				end
			end
			S_ADIV: div_start = !div_run_q;
			S_ASCAN, S_TWSCAN: wcmd = CMD_ROT;
			S_AINS: begin
				if (!dup_q) wcmd = CMD_INS;
				if (!hit_q) wpos = wcnt_q[WAW-1:0];
			end
			S_FSCAN, S_TRSCAN, S_TPOS, S_GSCAN: rcmd = CMD_ROT;
			S_FDEL: begin
				if (hit_q) rcmd = CMD_DEL;
			end
			S_TRINS: begin
				rcmd = CMD_INS;
				if (!gok_q) rpos = rcnt_q[RAW-1:0];
			end
			S_TWDEL: wcmd = CMD_DEL;
			default: wcmd = CMD_HOLD;
		endcase
	end

	always_comb begin
		g_code = ST_OK;
		if ({1'b0, wtap.id} == prev_head_q && last_p1 < {1'b0, gnew_q} &&
				reserved_q != 32'd0)
			g_code = ST_WORSE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wcnt_q <= '0;
			rcnt_q <= '0;
			reserved_q <= '0;
			prev_head_q <= '1;
			stale_q <= 1'b0;
			mode_q <= '0;
			cores_q <= 9'd1;
			div_run_q <= 1'b0;
			hit_q <= 1'b0;
			dup_q <= 1'b0;
			gok_q <= 1'b0;
			j_q <= '0;
			st_q <= ST_OK;
			started_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (paddr[2] == REG_CORES) begin
					cores_q <= pwdata[8:0];
					stale_q <= 1'b1;
				end else begin
					mode_q <= pwdata[2:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= ST_OK;
						started_q <= 1'b0;
						j_q <= '0;
						state_q <= stale_q ? S_NDIV : S_DISP;
					end
				end
				S_NDIV: begin
					if (!j_in_w || div_done) begin
						div_run_q <= 1'b0;
						j_q <= j_q + CW'(1);
						if (j_q == WLAST) begin
							stale_q <= 1'b0;
							state_q <= S_DISP;
						end
					end else if (!div_run_q) begin
						div_run_q <= 1'b1;
					end
				end
				S_DISP: begin
					j_q <= '0;
					hit_q <= 1'b0;
					dup_q <= 1'b0;
					gok_q <= 1'b0;
					case (op_q)
						OP_ARRIVE: begin
							if (wcnt_q == WFULL) begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_ADIV;
							end
						end
						OP_FINISH: state_q <= S_FSCAN;
						OP_TRY: begin
							if (rcnt_q != '0 && rtap.fin == now_q) begin
								state_q <= S_DONE;
							end else if (wcnt_q == '0) begin
								state_q <= S_DONE;
							end else begin
								if (now_q > reserved_q) st_q <= ST_MISSED;
								headn_q <= wtap.nodes;
								pick_q <= wtap;
								posw_q <= '0;
								hit_q <= freen_q >= wtap.nodes;
								acc_q <= ACC_W'(freen_q);
								state_q <= S_TRSCAN;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_ADIV: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						newn_q <= div_quo;
						state_q <= S_ASCAN;
					end
				end
				S_ASCAN: begin
					if (j_in_w && !hit_q) begin
						if (ahead(mode_q, nv, wtap)) begin
							posw_q <= j_q[WAW-1:0];
							hit_q <= 1'b1;
						end else if (!ahead(mode_q, wtap, nv)) begin
							dup_q <= 1'b1;
							hit_q <= 1'b1;
						end
					end
					j_q <= j_q + CW'(1);
					if (j_q == WLAST) state_q <= S_AINS;
				end
				S_AINS: begin
					if (dup_q) begin
						state_q <= S_DONE;
					end else begin
						wcnt_q <= wcnt_q + WCW'(1);
						state_q <= S_AHEAD;
					end
				end
				S_AHEAD: begin
					gfree_q <= freen_q;
					state_q <= (wtap.id == id_q) ? S_G0 : S_DONE;
				end
				S_FSCAN: begin
					if (j_in_r && !hit_q && rtap.id == id_q) begin
						posr_q <= j_q[RAW-1:0];
						hit_q <= 1'b1;
					end
					j_q <= j_q + CW'(1);
					if (j_q == RLAST) state_q <= S_FDEL;
				end
				S_FDEL: begin
					if (!hit_q) begin
						st_q <= ST_UNKNOWN;
						state_q <= S_DONE;
					end else begin
						rcnt_q <= rcnt_q - RCW'(1);
						gfree_q <= freen_q;
						state_q <= S_G0;
					end
				end
				S_TRSCAN: begin
					// Nodes free at the reservation: leading running jobs done by then.
					if (j_in_r && !dup_q) begin
						if (rtap.fin <= reserved_q) acc_q <= acc_n;
						else dup_q <= 1'b1;
					end
					j_q <= j_q + CW'(1);
					if (j_q == RLAST) begin
						j_q <= '0;
						state_q <= S_TWSCAN;
					end
				end
				S_TWSCAN: begin
					if (j_q != '0 && j_in_w && !hit_q && freen_q >= wtap.nodes) begin
						if (run_sum <= {1'b0, reserved_q} ||
								avail_left >= ACC_W'(headn_q)) begin
							hit_q <= 1'b1;
							pick_q <= wtap;
							posw_q <= j_q[WAW-1:0];
						end
					end
					j_q <= j_q + CW'(1);
					if (j_q == WLAST) state_q <= S_TFND;
				end
				S_TFND: begin
					j_q <= '0;
					gok_q <= 1'b0;
					if (!hit_q) begin
						state_q <= S_DONE;
					end else if (rcnt_q == RFULL) begin
						if (st_q == ST_OK) st_q <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						fin_q <= pick_sum[32] ? 32'hFFFF_FFFF : pick_sum[31:0];
						state_q <= S_TPOS;
					end
				end
				S_TPOS: begin
					if (j_in_r && !gok_q && rtap.fin > fin_q) begin
						posr_q <= j_q[RAW-1:0];
						gok_q <= 1'b1;
					end
					j_q <= j_q + CW'(1);
					if (j_q == RLAST) state_q <= S_TRINS;
				end
				S_TRINS: begin
					rcnt_q <= rcnt_q + RCW'(1);
					started_q <= 1'b1;
					sid_q <= pick_q.id;
					state_q <= S_TWDEL;
				end
				S_TWDEL: begin
					wcnt_q <= wcnt_q - WCW'(1);
					gfree_q <= (freen_q >= pick_q.nodes) ? (freen_q - pick_q.nodes) : 16'd0;
					state_q <= (posw_q == '0) ? S_G0 : S_DONE;
				end
				S_G0: begin
					j_q <= '0;
					acc_q <= ACC_W'(gfree_q);
					if (wcnt_q == '0) begin
						state_q <= S_DONE;
					end else if (gfree_q >= wtap.nodes) begin
						gnew_q <= now_q;
						gok_q <= 1'b1;
						state_q <= S_GEND;
					end else begin
						gok_q <= 1'b0;
						state_q <= S_GSCAN;
					end
				end
				S_GSCAN: begin
					if (j_in_r && !gok_q) begin
						acc_q <= acc_n;
						if (acc_n >= ACC_W'(wtap.nodes)) begin
							gnew_q <= rtap.fin;
							gok_q <= 1'b1;
						end
					end
					j_q <= j_q + CW'(1);
					if (j_q == RLAST) state_q <= S_GEND;
				end
				S_GEND: begin
					if (!gok_q) begin
						if (st_q == ST_OK) st_q <= ST_NORES;
					end else begin
						reserved_q <= gnew_q;
						prev_head_q <= {1'b0, wtap.id};
						if (st_q == ST_OK) st_q <= g_code;
					end
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			now_q <= now_time;
			id_q <= job_id;
			procs_q <= procs_needed;
			rt_q <= est_runtime;
			freen_q <= free_nodes;
		end
	end

	assign done = state_q == S_DONE;
	assign started = started_q;
	assign started_job = started_q ? sid_q : 16'd0;
	assign reservation = reserved_q;
	assign status = st_q;

	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= WFULL) else $error("waiting count beyond depth");
	a_rcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RFULL) else $error("running count beyond depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
	a_start_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && started) |-> (op_q == OP_TRY)) else $error("start reported for non-try");

endmodule
